FILE: sv/isolated_mismatch_snv_finder_defines.svh
// ------------------------------------------------------------------------
// Isolated mismatch SNV finder: assertion macros
// Shared property forms for the port checker.
// ------------------------------------------------------------------------
`ifndef ISOLATED_MISMATCH_SNV_FINDER_DEFINES_SVH
`define ISOLATED_MISMATCH_SNV_FINDER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define IMSF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define IMSF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks through reset.
`define IMSF_ASSERT_RST(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/imsf_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Isolated mismatch SNV finder: package
// Sizes, field widths and item kind codes.
// ------------------------------------------------------------------------
package imsf_pkg;

  localparam int MAX_TUMOUR_LEN = 128;
  // healthy depth is a power of two: the offset add wraps by truncation
  localparam int HEALTHY_DEPTH  = 256;
  localparam int RESULT_LIMIT   = 64;

  localparam int TADDR_W = $clog2(MAX_TUMOUR_LEN);
  localparam int HADDR_W = $clog2(HEALTHY_DEPTH);
  localparam int LEN_W   = $clog2(MAX_TUMOUR_LEN + 1);
  localparam int CNT_W   = $clog2(RESULT_LIMIT + 1);

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 8;
  localparam int BASE_W  = 2;
  localparam int OHANG_W = 7;
  localparam int TLEN_W  = 8;
  localparam int POS_W   = 7;

  localparam logic [KIND_W-1:0] KIND_LOAD_T = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_LOAD_H = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_EVAL   = KIND_W'(2);

endpackage

FILE: sv/imsf_ram.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// imsf_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ------------------------------------------------------------------------
module imsf_ram #(
  parameter int W = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/isolated_mismatch_snv_finder.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// isolated_mismatch_snv_finder
// Compares a loaded tumour read against a loaded healthy window and
// reports isolated single-base mismatches, or rejects the pair when two
// adjacent positions both mismatch.
// ------------------------------------------------------------------------
//
// Channel  Dir  Handshake             Word
// -------  ---  --------------------  -------------------------------------
// in_*     in   in_valid / in_ready   kind, index, base, strand, overhang,
//                                     tumour_length
// out_*    out  out_valid / out_ready snv_position, found, rejected, last
//
// Loads (tumour, healthy) and ignored kinds finish on acceptance, with the
// block left idle for the next word. An evaluate of length L (saturated
// to 2..128) runs a compare pass over the two base RAMs, then edge steps
// at 0 and L-1, a body pass over the isolation-flag RAM and a flush step.
// A rejection goes from the compare pass to the flush; the body pass is
// skipped for L = 2; the word limit cuts steps short. Each pass moves one
// RAM address per cycle while not stalled; the registered RAM read is
// the pacing element. Output stalls freeze the edge steps and body pass;
// the output register lets the last word wait while the next item is
// taken. Reset (rst_n low, synchronous) returns to idle, keeping RAM data.
// ------------------------------------------------------------------------
module isolated_mismatch_snv_finder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [imsf_pkg::KIND_W-1:0]  in_kind,
  input  logic [imsf_pkg::INDEX_W-1:0] in_index,
  input  logic [imsf_pkg::BASE_W-1:0]  in_base,
  input  logic                        in_strand,
  input  logic [imsf_pkg::OHANG_W-1:0] in_overhang,
  input  logic [imsf_pkg::TLEN_W-1:0]  in_tumour_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [imsf_pkg::POS_W-1:0]   out_snv_position,
  output logic                        out_found,
  output logic                        out_rejected,
  output logic                        out_last
);
  import imsf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,  // compare pass, builds isolation flags
    ST_EDGE0 = 6'b000100,  // position 0
    ST_EDGEL = 6'b001000,  // position L-1
    ST_BODY  = 6'b010000,  // positions 1..L-2 from the flag RAM
    ST_FLUSH = 6'b100000   // final word (last / empty / rejected)
  } state_t;

  state_t state_r, state_nxt;

  // evaluate parameters
  logic               strand_r;
  logic [OHANG_W-1:0] ohang_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   len_sat;
  logic [TADDR_W-1:0] len_m1, len_m2;

  // compare pass
  logic [TADDR_W-1:0] iss_cnt_r;
  logic               iss_done_r;
  logic               rv_r;
  logic [TADDR_W-1:0] rpos_r;
  logic               m0_r, m1_r, mp_r, mp2_r, rej_r;
  logic               scan_issue, mm, rej_hit, scan_last, iso_we, iso_bit;
  logic [TADDR_W-1:0] t_raddr, iso_waddr;
  logic [HADDR_W-1:0] h_raddr;
  logic [BASE_W-1:0]  t_rdata, h_rdata;
  logic               iso_rdata;

  // body pass
  logic [TADDR_W-1:0] bcnt_r, bpos_r;
  logic               bdone_r, brv_r, body_issue;

  // emit path: one pending position so the final one can carry last
  logic               pend_v_r;
  logic [TADDR_W-1:0] pend_pos_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               cand_v, stall, take, hit_limit, out_free;
  logic [TADDR_W-1:0] cand_pos;

  // output register
  logic               out_valid_r, out_load;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_rej_r, out_rej_nxt;
  logic               out_last_r, out_last_nxt;

  logic in_acc, eval_acc, t_we, h_we;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign eval_acc = in_acc && (in_kind == KIND_EVAL);
  assign t_we     = in_acc && (in_kind == KIND_LOAD_T) && (int'(in_index) < MAX_TUMOUR_LEN);
  assign h_we     = in_acc && (in_kind == KIND_LOAD_H) && (int'(in_index) < HEALTHY_DEPTH);

  always_comb begin
    if (int'(in_tumour_length) < 2) begin
      len_sat = LEN_W'(2);
    end else if (int'(in_tumour_length) > MAX_TUMOUR_LEN) begin
      len_sat = LEN_W'(MAX_TUMOUR_LEN);
    end else begin
      len_sat = LEN_W'(in_tumour_length);
    end
  end

  assign len_m1 = TADDR_W'(len_r - LEN_W'(1));
  assign len_m2 = TADDR_W'(len_r - LEN_W'(2));

  // ---- base stores --------------------------------------------------
  assign scan_issue = (state_r == ST_SCAN) && !iss_done_r;
  // reverse strand walks the tumour read from its far end
  assign t_raddr = strand_r ? TADDR_W'(len_m1 - iss_cnt_r) : iss_cnt_r;
  assign h_raddr = HADDR_W'(HADDR_W'(iss_cnt_r) + HADDR_W'(ohang_r));

  imsf_ram #(.W(BASE_W), .DEPTH(MAX_TUMOUR_LEN)) u_tumour_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (TADDR_W'(in_index)),
    .wdata (in_base),
    .re    (scan_issue),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  imsf_ram #(.W(BASE_W), .DEPTH(HEALTHY_DEPTH)) u_healthy_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (HADDR_W'(in_index)),
    .wdata (in_base),
    .re    (scan_issue),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // complement of a 2-bit base code is its bitwise inverse
  assign mm        = (strand_r ? ~t_rdata : t_rdata) != h_rdata;
  assign rej_hit   = rv_r && (rpos_r != '0) && mm && mp_r;
  assign scan_last = rv_r && (rpos_r == len_m1);

  // body position rpos-1 is isolated once its right neighbour is known
  assign iso_bit   = !mp2_r && mp_r && !mm;
  assign iso_we    = rv_r && (rpos_r >= TADDR_W'(2));
  assign iso_waddr = TADDR_W'(rpos_r - TADDR_W'(1));

  // flag RAM: written only in SCAN, read only in BODY, so no overlap
  imsf_ram #(.W(1), .DEPTH(MAX_TUMOUR_LEN)) u_iso_ram (
    .clk   (clk),
    .we    (iso_we),
    .waddr (iso_waddr),
    .wdata (iso_bit),
    .re    (body_issue),
    .raddr (bcnt_r),
    .rdata (iso_rdata)
  );

  // ---- emit path ----------------------------------------------------
  always_comb begin
    cand_v   = 1'b0;
    cand_pos = '0;
    unique case (state_r)
      ST_EDGE0: begin
        cand_v = m0_r && !m1_r;
      end
      ST_EDGEL: begin
        cand_v   = mp_r && !mp2_r;
        cand_pos = len_m1;
      end
      ST_BODY: begin
        cand_v   = brv_r && iso_rdata;
        cand_pos = bpos_r;
      end
      default: begin
        cand_v = 1'b0;
      end
    endcase
  end

  assign out_free   = !out_valid_r || out_ready;
  assign stall      = cand_v && pend_v_r && !out_free;
  assign take       = cand_v && !stall;
  assign hit_limit  = take && (cnt_r == CNT_W'(RESULT_LIMIT - 1));
  assign body_issue = (state_r == ST_BODY) && !bdone_r && !stall && !hit_limit;

  always_comb begin
    out_load      = 1'b0;
    out_pos_nxt   = POS_W'(pend_pos_r);
    out_found_nxt = 1'b1;
    out_rej_nxt   = 1'b0;
    out_last_nxt  = 1'b0;
    if (take && pend_v_r) begin
      out_load = 1'b1;
    end else if ((state_r == ST_FLUSH) && out_free) begin
      out_load     = 1'b1;
      out_last_nxt = 1'b1;
      if (!pend_v_r) begin
        // empty or rejected evaluation
        out_pos_nxt   = '0;
        out_found_nxt = 1'b0;
        out_rej_nxt   = rej_r;
      end
    end
  end

  // ---- sequencer ----------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (eval_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = (rej_r || rej_hit) ? ST_FLUSH : ST_EDGE0;
      end
      ST_EDGE0: begin
        if (!stall) state_nxt = hit_limit ? ST_FLUSH : ST_EDGEL;
      end
      ST_EDGEL: begin
        if (!stall) begin
          state_nxt = (hit_limit || (len_r == LEN_W'(2))) ? ST_FLUSH : ST_BODY;
        end
      end
      ST_BODY: begin
        if (hit_limit || (brv_r && !stall && (bpos_r == len_m2))) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_done_r  <= 1'b0;
      rv_r        <= 1'b0;
      rej_r       <= 1'b0;
      bdone_r     <= 1'b0;
      brv_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      iss_cnt_r   <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (eval_acc) begin
        iss_cnt_r  <= '0;
        iss_done_r <= 1'b0;
        rv_r       <= 1'b0;
        rej_r      <= 1'b0;
        bcnt_r     <= TADDR_W'(1);
        bdone_r    <= 1'b0;
        brv_r      <= 1'b0;
        pend_v_r   <= 1'b0;
        cnt_r      <= '0;
      end

      if (state_r == ST_SCAN) begin
        rv_r <= scan_issue;
        if (scan_issue) begin
          iss_cnt_r  <= iss_cnt_r + TADDR_W'(1);
          iss_done_r <= (iss_cnt_r == len_m1);
        end
        if (rej_hit) rej_r <= 1'b1;
      end

      if ((state_r == ST_BODY) && !stall) begin
        brv_r <= body_issue;
        if (body_issue) begin
          bcnt_r  <= bcnt_r + TADDR_W'(1);
          bdone_r <= (bcnt_r == len_m2);
        end
      end

      if (take) begin
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + CNT_W'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      strand_r <= in_strand;
      ohang_r  <= in_overhang;
      len_r    <= len_sat;
    end
    if (scan_issue) begin
      rpos_r <= iss_cnt_r;
    end
    if ((state_r == ST_SCAN) && rv_r) begin
      mp_r  <= mm;
      mp2_r <= mp_r;
      if (rpos_r == TADDR_W'(0)) m0_r <= mm;
      if (rpos_r == TADDR_W'(1)) m1_r <= mm;
    end
    if (body_issue) begin
      bpos_r <= bcnt_r;
    end
    if (take) begin
      pend_pos_r <= cand_pos;
    end
    if (out_load) begin
      out_pos_r   <= out_pos_nxt;
      out_found_r <= out_found_nxt;
      out_rej_r   <= out_rej_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_snv_position = out_pos_r;
  assign out_found        = out_found_r;
  assign out_rejected     = out_rej_r;
  assign out_last         = out_last_r;

endmodule

FILE: sv/imsf_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// imsf_checker
// Port-level checks on the result channel of the SNV finder.
// ------------------------------------------------------------------------
`include "isolated_mismatch_snv_finder_defines.svh"

module imsf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [imsf_pkg::POS_W-1:0] out_snv_position,
  input logic                      out_found,
  input logic                      out_rejected,
  input logic                      out_last
);
  import imsf_pkg::*;

  // result word as one vector, for the hold check
  logic [POS_W+2:0] out_word;
  logic             stalled;
  logic             nopos_ok;

  assign out_word = {out_snv_position, out_found, out_rejected, out_last};
  assign stalled  = out_valid && !out_ready;
  assign nopos_ok = out_last && (out_snv_position == '0);

  // a word with a position is never a reject
  `IMSF_ASSERT_IMP(a_found_not_rej, clk, rst_n, out_valid && out_found, !out_rejected, "found and rejected")

  // empty and rejected words close the evaluation and carry no position
  `IMSF_ASSERT_IMP(a_nopos_last, clk, rst_n, out_valid && !out_found, nopos_ok, "bad empty word")

  // stalled word holds
  `IMSF_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_word), "held word changed")

  // reset leaves the block idle with nothing to deliver
  `IMSF_ASSERT_RST(a_reset_idle, clk, !rst_n, !out_valid && in_ready, "not idle after reset")

endmodule

bind isolated_mismatch_snv_finder imsf_checker u_imsf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_snv_position (out_snv_position),
  .out_found        (out_found),
  .out_rejected     (out_rejected),
  .out_last         (out_last)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_top: isolated_mismatch_snv_finder testbench
// Loads tumour reads and healthy windows with planted mismatch patterns,
// evaluates them on both strands, and checks every result word against an
// in-bench mismatch caller or a directed expected word. Both handshakes stall at random.
// ------------------------------------------------------------------------
module tb_top;
  import imsf_pkg::*;

  // kind code that the block decodes as nothing
  localparam logic [KIND_W-1:0] KIND_SPARE = KIND_W'(3);

  localparam int RESET_CYCLES = 11;
  // input words in the whole run
  localparam int ITEM_TARGET  = 460;
  // worst evaluate: its passes plus 64 words each held up by back-pressure;
  // about five hundred input words, each after a random idle gap
  localparam int CYCLE_LIMIT  = 100000;
  // longest evaluate still running after the last expected word
  localparam int DRAIN_CYCLES = 2 * MAX_TUMOUR_LEN + 40;
  localparam int REPORT_LIMIT = 10;

  // one input word, every field random unless a caller sets it
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [BASE_W-1:0]  base;
    logic               strand;
    logic [OHANG_W-1:0] overhang;
    logic [TLEN_W-1:0]  tlen;
  } in_word_t;

  localparam int IN_W = $bits(in_word_t);

  // one result word
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             found;
    logic             rejected;
    logic             last;
  } snv_word_t;

  localparam snv_word_t UNTYPED    = '0;
  localparam snv_word_t EMPTY_CALL = {POS_W'(0), 1'b0, 1'b0, 1'b1};
  localparam snv_word_t REJECTION  = {POS_W'(0), 1'b0, 1'b1, 1'b1};

  // directed table: an evaluate row gets a fill of both stores first
  typedef struct {
    in_word_t                  w;
    logic [MAX_TUMOUR_LEN-1:0] mm;     // tumour positions given a mismatch
    bit                        typed;  // exp holds the single word expected
    snv_word_t                 exp;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [INDEX_W-1:0]  in_index;
  logic [BASE_W-1:0]   in_base;
  logic                in_strand;
  logic [OHANG_W-1:0]  in_overhang;
  logic [TLEN_W-1:0]   in_tumour_length;
  logic                out_valid;
  logic                out_ready;
  logic [POS_W-1:0]    out_snv_position;
  logic                out_found;
  logic                out_rejected;
  logic                out_last;

  isolated_mismatch_snv_finder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_index         (in_index),
    .in_base          (in_base),
    .in_strand        (in_strand),
    .in_overhang      (in_overhang),
    .in_tumour_length (in_tumour_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_snv_position (out_snv_position),
    .out_found        (out_found),
    .out_rejected     (out_rejected),
    .out_last         (out_last)
  );

  // bench copy of the stores, plus which entries have been written
  logic [BASE_W-1:0] tumour_bases  [MAX_TUMOUR_LEN];
  logic [BASE_W-1:0] healthy_bases [HEALTHY_DEPTH];
  bit                tumour_written  [MAX_TUMOUR_LEN];
  bit                healthy_written [HEALTHY_DEPTH];

  // result words still owed by the block, oldest first
  snv_word_t snv_calls_q [$];

  plan_row_t plan [$];

  int unsigned cycles;
  int fail_count;
  int words_sent;
  int evals_sent;
  int words_checked;
  int positions_seen;
  int rejects_seen;
  int empties_seen;
  bit in_calm;
  bit out_calm;

  // ---------------------------------------------------------------------
  // Clock, cycle count and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words still owed", cycles, snv_calls_q.size());
    $display("isolated_mismatch_snv_finder test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------

  // Idle cycles before the next word on one side. Each side flips now and
  // then into a calm stretch where it never idles.
  function automatic int next_gap(inout bit calm);
    if ($urandom_range(0, 11) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // length field saturates to 2..MAX_TUMOUR_LEN
  function automatic int sat_len(logic [TLEN_W-1:0] tl);
    if (tl < 2) return 2;
    if (tl > MAX_TUMOUR_LEN) return MAX_TUMOUR_LEN;
    return int'(tl);
  endfunction

  function automatic snv_word_t mk_word(int pos, bit found, bit rejected, bit last);
    snv_word_t wd;
    wd.pos      = POS_W'(pos);
    wd.found    = found;
    wd.rejected = rejected;
    wd.last     = last;
    return wd;
  endfunction

  // append one word to what the block still owes
  function automatic void owe_word(snv_word_t wd);
    snv_calls_q = {snv_calls_q, wd};
  endfunction

  function automatic in_word_t rand_word();
    logic [IN_W-1:0] r;
    r = IN_W'($urandom);
    return in_word_t'(r);
  endfunction

  // mismatch mask with up to three planted positions (negative = none)
  function automatic logic [MAX_TUMOUR_LEN-1:0] spots(int a, int b, int c);
    logic [MAX_TUMOUR_LEN-1:0] m;
    m = '0;
    if (a >= 0) m[a] = 1'b1;
    if (b >= 0) m[b] = 1'b1;
    if (c >= 0) m[c] = 1'b1;
    return m;
  endfunction

  function automatic void add_row(int kind, int index, int base, int strand, int ohang,
                                  int tlen, logic [MAX_TUMOUR_LEN-1:0] mm, bit typed,
                                  snv_word_t exp);
    plan_row_t row;
    row.w.kind     = KIND_W'(kind);
    row.w.index    = INDEX_W'(index);
    row.w.base     = BASE_W'(base);
    row.w.strand   = strand[0];
    row.w.overhang = OHANG_W'(ohang);
    row.w.tlen     = TLEN_W'(tlen);
    row.mm         = mm;
    row.typed      = typed;
    row.exp        = exp;
    plan = {plan, row};
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch caller: the words one evaluate must produce
  // ---------------------------------------------------------------------
  function automatic void call_snvs(in_word_t w);
    int                len;
    bit                mis [MAX_TUMOUR_LEN];
    logic [BASE_W-1:0] t;
    snv_word_t         hits [$];
    len = sat_len(w.tlen);
    // reverse strand reads the tumour backwards and complemented; on two
    // bits the complement (A<->T, C<->G) is plain inversion
    for (int i = 0; i < len; i++) begin
      t = w.strand ? ~tumour_bases[len - 1 - i] : tumour_bases[i];
      mis[i] = (t != healthy_bases[(i + w.overhang) % HEALTHY_DEPTH]);
    end
    // any adjacent pair looks like an indel: one rejection word, nothing else
    for (int i = 0; i + 1 < len; i++) begin
      if (mis[i] && mis[i + 1]) begin
        owe_word(REJECTION);
        return;
      end
    end
    // order: first position, last position, then the body ascending
    if (mis[0] && !mis[1]) hits = {hits, mk_word(0, 1'b1, 1'b0, 1'b0)};
    if (mis[len - 1] && !mis[len - 2]) hits = {hits, mk_word(len - 1, 1'b1, 1'b0, 1'b0)};
    for (int i = 1; i + 1 < len; i++) begin
      if (!mis[i - 1] && mis[i] && !mis[i + 1]) hits = {hits, mk_word(i, 1'b1, 1'b0, 1'b0)};
    end
    while (hits.size() > RESULT_LIMIT) hits.delete(hits.size() - 1);
    if (hits.size() == 0) begin
      owe_word(EMPTY_CALL);
    end else begin
      hits[hits.size() - 1].last = 1'b1;
      foreach (hits[k]) owe_word(hits[k]);
    end
  endfunction

  // bench side effect of one accepted word
  function automatic void apply_word(in_word_t w);
    case (w.kind)
      KIND_LOAD_T: begin
        // index past the tumour store is dropped by the block
        if (w.index < MAX_TUMOUR_LEN) begin
          tumour_bases[w.index]   = w.base;
          tumour_written[w.index] = 1'b1;
        end
      end
      KIND_LOAD_H: begin
        if (w.index < HEALTHY_DEPTH) begin
          healthy_bases[w.index]   = w.base;
          healthy_written[w.index] = 1'b1;
        end
      end
      KIND_EVAL: call_snvs(w);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Drive one word and hold it until accepted. Called at a rising edge; on
  // a zero gap valid simply stays high with the new payload.
  task automatic send_word(in_word_t w, bit typed, snv_word_t typed_word);
    int gap;
    gap = next_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= w.kind;
    in_index         <= w.index;
    in_base          <= w.base;
    in_strand        <= w.strand;
    in_overhang      <= w.overhang;
    in_tumour_length <= w.tlen;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.kind == KIND_EVAL) evals_sent++;
    if (typed) owe_word(typed_word);
    else apply_word(w);
  endtask

  // Load a tumour read and the matching healthy window, with healthy bases
  // changed at the positions in mm, then evaluate. Store order varies.
  task automatic run_read(logic strand, logic [OHANG_W-1:0] ohang, logic [TLEN_W-1:0] tlen,
                          logic [MAX_TUMOUR_LEN-1:0] mm, bit typed, snv_word_t typed_word);
    int                len;
    bit                healthy_first;
    logic [BASE_W-1:0] tum [MAX_TUMOUR_LEN];
    logic [BASE_W-1:0] hea [MAX_TUMOUR_LEN];
    in_word_t          w;
    len = sat_len(tlen);
    healthy_first = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) tum[i] = BASE_W'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      hea[i] = strand ? ~tum[len - 1 - i] : tum[i];
      // a nonzero xor always lands on a different base
      if (mm[i]) hea[i] = hea[i] ^ BASE_W'($urandom_range(1, 3));
    end
    for (int pass = 0; pass < 2; pass++) begin
      for (int i = 0; i < len; i++) begin
        w = rand_word();
        if ((pass == 0) == healthy_first) begin
          w.kind  = KIND_LOAD_H;
          w.index = INDEX_W'((i + ohang) % HEALTHY_DEPTH);
          w.base  = hea[i];
        end else begin
          w.kind  = KIND_LOAD_T;
          w.index = INDEX_W'(i);
          w.base  = tum[i];
        end
        send_word(w, 1'b0, UNTYPED);
      end
    end
    w          = rand_word();
    w.kind     = KIND_EVAL;
    w.strand   = strand;
    w.overhang = ohang;
    w.tlen     = tlen;
    send_word(w, typed, typed_word);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int                        pick;
    int                        len;
    int                        density;
    bit                        ok;
    logic [TLEN_W-1:0]         tl;
    logic [MAX_TUMOUR_LEN-1:0] mm;
    in_word_t                  w;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_LOAD_T;
    in_index         <= '0;
    in_base          <= '0;
    in_strand        <= 1'b0;
    in_overhang      <= '0;
    in_tumour_length <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: kind, index, base, strand, overhang, length field,
    // planted mismatches, then the single expected word where obvious
    add_row(KIND_SPARE, 77, 1, 1, 127, 255, '0, 1'b0, UNTYPED);
    add_row(KIND_LOAD_T, 255, 3, 0, 0, 0, '0, 1'b0, UNTYPED);   // past the store
    add_row(KIND_LOAD_H, 255, 3, 1, 0, 0, '0, 1'b0, UNTYPED);   // top entry
    add_row(KIND_EVAL, 0, 0, 0, 0, 2, '0, 1'b1, EMPTY_CALL);
    add_row(KIND_EVAL, 0, 0, 0, 9, 0, spots(0, -1, -1), 1'b1,
            mk_word(0, 1'b1, 1'b0, 1'b1));                      // length 0 -> 2
    add_row(KIND_EVAL, 0, 0, 1, 3, 1, spots(1, -1, -1), 1'b1,
            mk_word(1, 1'b1, 1'b0, 1'b1));                      // length 1 -> 2
    add_row(KIND_EVAL, 0, 0, 0, 0, 2, spots(0, 1, -1), 1'b1, REJECTION);
    add_row(KIND_EVAL, 0, 0, 1, 5, 8, spots(3, -1, -1), 1'b1,
            mk_word(3, 1'b1, 1'b0, 1'b1));
    add_row(KIND_EVAL, 0, 0, 0, 17, 10, spots(0, 9, 4), 1'b0, UNTYPED);
    add_row(KIND_EVAL, 0, 0, 0, 1, 3, spots(0, 2, -1), 1'b0, UNTYPED);
    add_row(KIND_EVAL, 0, 0, 0, 1, 3, spots(1, -1, -1), 1'b1,
            mk_word(1, 1'b1, 1'b0, 1'b1));
    // an adjacent pair wins over isolated hits elsewhere
    add_row(KIND_EVAL, 0, 0, 0, 30, 12, spots(0, 5, 6), 1'b1, REJECTION);
    add_row(KIND_EVAL, 0, 0, 1, 127, 8, spots(6, 7, -1), 1'b1, REJECTION);
    add_row(KIND_EVAL, 0, 0, 1, 42, 12, spots(0, 11, 2), 1'b0, UNTYPED);
    // densest legal pattern: 0, 2..124 even, 127 -> exactly the word limit
    add_row(KIND_EVAL, 0, 0, 0, 127, 255, {1'b1, 1'b0, {63{2'b01}}}, 1'b0, UNTYPED);
    add_row(KIND_EVAL, 0, 0, 1, 64, 9, spots(0, 8, -1), 1'b0, UNTYPED);
    add_row(KIND_EVAL, 0, 0, 0, 100, 6, '0, 1'b1, EMPTY_CALL);

    foreach (plan[r]) begin
      if (plan[r].w.kind == KIND_EVAL)
        run_read(plan[r].w.strand, plan[r].w.overhang, plan[r].w.tlen, plan[r].mm,
                 plan[r].typed, plan[r].exp);
      else
        send_word(plan[r].w, 1'b0, UNTYPED);
    end

    // random part: mostly well-formed reads, some re-evaluations of what
    // is loaded, some stray loads and spare kinds
    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_TUMOUR_LEN)
                                          : $urandom_range(2, 12);
        // keep the run near the item budget
        while (len > 2 && 2 * len + 1 > ITEM_TARGET - words_sent) len--;
        tl = TLEN_W'(len);
        if (len == 2 && $urandom_range(0, 3) == 0) tl = TLEN_W'($urandom_range(0, 1));
        if (len == MAX_TUMOUR_LEN && $urandom_range(0, 1) == 0)
          tl = TLEN_W'($urandom_range(MAX_TUMOUR_LEN + 1, 255));
        // density 0 is a clean read; higher densities make pairs likelier
        density = $urandom_range(0, 3);
        mm = '0;
        for (int i = 0; i < len; i++) mm[i] = ($urandom_range(0, 15) < 2 * density);
        run_read($urandom_range(0, 1) != 0, OHANG_W'($urandom_range(0, 127)), tl, mm,
                 1'b0, UNTYPED);
      end else if (pick < 84) begin
        // only windows where every base read has been written
        ok = 1'b0;
        for (int tries = 0; tries < 8 && !ok; tries++) begin
          w = rand_word();
          w.kind = KIND_EVAL;
          if ($urandom_range(0, 3) != 0) w.tlen = TLEN_W'($urandom_range(0, 16));
          ok = 1'b1;
          for (int i = 0; i < sat_len(w.tlen); i++) begin
            if (!tumour_written[i] || !healthy_written[(i + w.overhang) % HEALTHY_DEPTH])
              ok = 1'b0;
          end
        end
        if (ok) send_word(w, 1'b0, UNTYPED);
      end else if (pick < 92) begin
        w = rand_word();
        w.kind = ($urandom_range(0, 1) != 0) ? KIND_LOAD_T : KIND_LOAD_H;
        send_word(w, 1'b0, UNTYPED);
      end else begin
        w = rand_word();
        w.kind = KIND_SPARE;
        send_word(w, 1'b0, UNTYPED);
      end
    end

    in_valid <= 1'b0;
    while (snv_calls_q.size() != 0) @(posedge clk);
    // let any word that was never predicted show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input words (%0d evaluations) in %0d cycles", words_sent, evals_sent,
             cycles);
    $display("%0d result words checked: %0d positions, %0d rejections, %0d empty; %0d bad",
             words_checked, positions_seen, rejects_seen, empties_seen, fail_count);
    if (fail_count == 0) $display("isolated_mismatch_snv_finder test passed");
    else $display("isolated_mismatch_snv_finder test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and the check of each word
  // ---------------------------------------------------------------------
  initial begin : result_side
    int        gap;
    snv_word_t got;
    snv_word_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = next_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      // word taken at this edge
      got = {out_snv_position, out_found, out_rejected, out_last};
      words_checked++;
      if (snv_calls_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("cycle %0d: word with nothing owed: ", cycles,
                   "pos=%0d found=%0b rej=%0b last=%0b",
                   got.pos, got.found, got.rejected, got.last);
      end else begin
        want = snv_calls_q.pop_front();
        if (want.found) positions_seen++;
        else if (want.rejected) rejects_seen++;
        else empties_seen++;
        if (got.pos !== want.pos || got.found !== want.found ||
            got.rejected !== want.rejected || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("cycle %0d: expected pos=%0d found=%0b rej=%0b last=%0b, ",
                     cycles, want.pos, want.found, want.rejected, want.last,
                     "got pos=%0d found=%0b rej=%0b last=%0b",
                     got.pos, got.found, got.rejected, got.last);
        end
      end
    end
  end

endmodule

FILE: sim.f
+incdir+sv
sv/imsf_pkg.sv
sv/imsf_ram.sv
sv/isolated_mismatch_snv_finder.sv
sv/imsf_checker.sv
test/tb_top.sv
